/* design/gsb_pkg.sv */
// Shared types and constants for the grid surface bilinear sampler.
package gsb_pkg;

    localparam int DIM_W      = 7;
    localparam int IDX_W      = 6;
    localparam int FRAC_W     = 16;
    localparam int COORD_W    = 32;
    localparam int LANES      = 3;
    localparam int UV_W       = 18;
    localparam int UNIT_W     = 17;
    localparam int FU_W       = UNIT_W + DIM_W;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int PT_W       = LANES * COORD_W;
    localparam int IN_DATA_W  = 2 * IDX_W + PT_W + 2 * UV_W;
    localparam int OUT_DATA_W = PT_W;

    typedef logic [DIM_W-1:0] dim_t;

    localparam dim_t DIM_RESET = 7'd64;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd2;

    localparam logic [UNIT_W-1:0] UNIT_ONE = 17'h10000;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_WRITE,
        OP_READ,
        OP_SAMPLE,
        OP_FLAG
    } op_t;

    typedef struct packed {
        dim_t rows;
        dim_t cols;
    } dims_t;

    // one classified word handed from front to back
    typedef struct packed {
        op_t               op;
        dim_t              r0;
        dim_t              r1;
        dim_t              c0;
        dim_t              c1;
        logic [FRAC_W-1:0] tc;
        logic [FRAC_W-1:0] tr;
        logic [PT_W-1:0]   pdata;
    } desc_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_PUSH
    } fstate_t;

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_WRITE,
        B_RD0,
        B_RD1,
        B_S0,
        B_S1,
        B_S2,
        B_S3,
        B_S4,
        B_S5,
        B_S6,
        B_S7,
        B_OUT
    } bstate_t;

endpackage

/* design/grid_surface_bilinear_sampler.sv */
// Top level: config registers, front end, descriptor queue and back end.
// The back end runs one descriptor at a time; a sample makes four corner reads
// through the single RAM port and three passes through the per-lane lerp multiplier.
// The front end takes a new word only after it has pushed the last descriptor.
// After reset the point RAM is swept to zero with s_axis_tready low; config
// writes are taken during the sweep.
module grid_surface_bilinear_sampler #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // row, col, px, py, pz, u_coord, v_coord
    input  logic [gsb_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // cmd
    input  logic [gsb_pkg::CMD_W-1:0]         s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // ox, oy, oz
    output logic [gsb_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // status
    output logic                              m_axis_tuser,
    input  logic                              cfg_we,
    input  logic [gsb_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [gsb_pkg::DIM_W-1:0]         cfg_wdata
);

    gsb_pkg::dim_t  grid_rows_reg;
    gsb_pkg::dim_t  grid_cols_reg;
    gsb_pkg::dims_t dims;

    logic           clearing;
    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;
    gsb_pkg::desc_t q_din;
    gsb_pkg::desc_t q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= gsb_pkg::DIM_RESET;
            grid_cols_reg <= gsb_pkg::DIM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                gsb_pkg::REG_GRID_ROWS: grid_rows_reg <= cfg_wdata;
                gsb_pkg::REG_GRID_COLS: grid_cols_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // dims saturated to [1, MAX]
    always_comb
    begin
        if (grid_rows_reg == '0)
        begin
            dims.rows = gsb_pkg::dim_t'(1);
        end
        else if (int'(grid_rows_reg) > MAX_ROWS)
        begin
            dims.rows = gsb_pkg::dim_t'(MAX_ROWS);
        end
        else
        begin
            dims.rows = grid_rows_reg;
        end
        if (grid_cols_reg == '0)
        begin
            dims.cols = gsb_pkg::dim_t'(1);
        end
        else if (int'(grid_cols_reg) > MAX_COLS)
        begin
            dims.cols = gsb_pkg::dim_t'(MAX_COLS);
        end
        else
        begin
            dims.cols = grid_cols_reg;
        end
    end

    gsb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .enable   (!clearing),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_cmd   (s_axis_tuser),
        .in_data  (s_axis_tdata),
        .dims     (dims),
        .q_full   (q_full),
        .push     (q_push),
        .desc     (q_din)
    );

    gsb_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_head),
        .empty (q_empty)
    );

    gsb_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .clearing   (clearing),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_status (m_axis_tuser)
    );

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !s_axis_tready)
        else $error("input accepted during RAM clear");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty queue");

    a_flag_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("flagged word carries nonzero point");

endmodule

/* design/gsb_ram.sv */
// Generic single-port RAM with registered read.
module gsb_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/gsb_front.sv */
// Front end: accepts words, scales u/v and classifies them into descriptors.
module gsb_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          enable,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [gsb_pkg::CMD_W-1:0]     in_cmd,
    input  logic [gsb_pkg::IN_DATA_W-1:0] in_data,
    input  gsb_pkg::dims_t                dims,
    input  logic                          q_full,
    output logic                          push,
    output gsb_pkg::desc_t                desc
);

    localparam int ROW_LO = 0;
    localparam int COL_LO = ROW_LO + gsb_pkg::IDX_W;
    localparam int PT_LO  = COL_LO + gsb_pkg::IDX_W;
    localparam int U_LO   = PT_LO + gsb_pkg::PT_W;
    localparam int V_LO   = U_LO + gsb_pkg::UV_W;

    gsb_pkg::fstate_t state_reg, state_next;

    logic [gsb_pkg::CMD_W-1:0]  cmd_reg;
    logic [gsb_pkg::IDX_W-1:0]  row_reg;
    logic [gsb_pkg::IDX_W-1:0]  col_reg;
    logic [gsb_pkg::PT_W-1:0]   pdata_reg;
    logic [gsb_pkg::UNIT_W-1:0] u_reg;
    logic [gsb_pkg::UNIT_W-1:0] v_reg;
    logic [gsb_pkg::FU_W-1:0]   fu_reg;
    logic [gsb_pkg::FU_W-1:0]   fv_reg;

    gsb_pkg::dim_t cols_m1;
    gsb_pkg::dim_t rows_m1;
    logic [gsb_pkg::DIM_W:0] cw;
    logic [gsb_pkg::DIM_W:0] rw;
    gsb_pkg::dim_t c0;
    gsb_pkg::dim_t r0;
    logic in_range;
    logic accept;

    function automatic logic [gsb_pkg::UNIT_W-1:0] clamp_unit(
        input logic signed [gsb_pkg::UV_W-1:0] t
    );
        logic [gsb_pkg::UNIT_W-1:0] r;
        if (t[gsb_pkg::UV_W-1])
        begin
            r = '0;
        end
        else if (t > 18'sd65536)
        begin
            r = gsb_pkg::UNIT_ONE;
        end
        else
        begin
            r = t[gsb_pkg::UNIT_W-1:0];
        end
        return r;
    endfunction

    assign cols_m1 = dims.cols - gsb_pkg::dim_t'(1);
    assign rows_m1 = dims.rows - gsb_pkg::dim_t'(1);
    assign accept  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gsb_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        push       = 1'b0;
        case (state_reg)
            gsb_pkg::F_IDLE:
            begin
                in_ready = enable;
                if (in_valid && enable)
                begin
                    state_next = gsb_pkg::F_MUL;
                end
            end
            gsb_pkg::F_MUL:
            begin
                state_next = gsb_pkg::F_PUSH;
            end
            gsb_pkg::F_PUSH:
            begin
                push = !q_full;
                if (!q_full)
                begin
                    state_next = gsb_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = gsb_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= in_cmd;
            row_reg   <= in_data[ROW_LO +: gsb_pkg::IDX_W];
            col_reg   <= in_data[COL_LO +: gsb_pkg::IDX_W];
            pdata_reg <= in_data[PT_LO +: gsb_pkg::PT_W];
            u_reg     <= clamp_unit(in_data[U_LO +: gsb_pkg::UV_W]);
            v_reg     <= clamp_unit(in_data[V_LO +: gsb_pkg::UV_W]);
        end
        if (state_reg == gsb_pkg::F_MUL)
        begin
            fu_reg <= gsb_pkg::FU_W'(u_reg) * gsb_pkg::FU_W'(cols_m1);
            fv_reg <= gsb_pkg::FU_W'(v_reg) * gsb_pkg::FU_W'(rows_m1);
        end
    end

    // cell index, clamped to the last row/column
    assign cw = fu_reg[gsb_pkg::FU_W-1:gsb_pkg::FRAC_W];
    assign rw = fv_reg[gsb_pkg::FU_W-1:gsb_pkg::FRAC_W];
    assign c0 = ({1'b0, cols_m1} < cw) ? cols_m1 : cw[gsb_pkg::DIM_W-1:0];
    assign r0 = ({1'b0, rows_m1} < rw) ? rows_m1 : rw[gsb_pkg::DIM_W-1:0];

    assign in_range = ({1'b0, row_reg} < dims.rows) && ({1'b0, col_reg} < dims.cols);

    always_comb
    begin
        desc.op    = gsb_pkg::OP_NOP;
        desc.r0    = {1'b0, row_reg};
        desc.c0    = {1'b0, col_reg};
        desc.r1    = {1'b0, row_reg};
        desc.c1    = {1'b0, col_reg};
        desc.tc    = fu_reg[gsb_pkg::FRAC_W-1:0];
        desc.tr    = fv_reg[gsb_pkg::FRAC_W-1:0];
        desc.pdata = pdata_reg;
        case (cmd_reg)
            gsb_pkg::CMD_WRITE:
            begin
                desc.op = in_range ? gsb_pkg::OP_WRITE : gsb_pkg::OP_FLAG;
            end
            gsb_pkg::CMD_READ:
            begin
                desc.op = in_range ? gsb_pkg::OP_READ : gsb_pkg::OP_FLAG;
            end
            gsb_pkg::CMD_SAMPLE:
            begin
                desc.op = gsb_pkg::OP_SAMPLE;
                desc.r0 = r0;
                desc.c0 = c0;
                desc.r1 = ({1'b0, r0} + 8'd1 < {1'b0, dims.rows}) ?
                          r0 + gsb_pkg::dim_t'(1) : r0;
                desc.c1 = ({1'b0, c0} + 8'd1 < {1'b0, dims.cols}) ?
                          c0 + gsb_pkg::dim_t'(1) : c0;
            end
            default:
            begin
                desc.op = gsb_pkg::OP_NOP;
            end
        endcase
    end

endmodule

/* design/gsb_queue.sv */
// Two-entry descriptor queue between front and back.
module gsb_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  gsb_pkg::desc_t din,
    output logic           full,
    input  logic           pop,
    output gsb_pkg::desc_t dout,
    output logic           empty
);

    gsb_pkg::desc_t mem_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

/* design/gsb_back.sv */
// Back end: point memory, corner fetch sequencer, lerp lanes and output register.
module gsb_back #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    input  gsb_pkg::desc_t                 q_head,
    output logic                           q_pop,
    output logic                           clearing,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [gsb_pkg::OUT_DATA_W-1:0] out_data,
    output logic                           out_status
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] COLS_A    = AW'(MAX_COLS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    gsb_pkg::bstate_t state_reg, state_next;

    logic [AW-1:0]   clr_addr_reg;
    gsb_pkg::desc_t  desc_reg;

    logic [gsb_pkg::COORD_W-1:0] a_reg    [gsb_pkg::LANES];
    logic [gsb_pkg::COORD_W-1:0] c_reg    [gsb_pkg::LANES];
    logic [gsb_pkg::COORD_W-1:0] top_reg  [gsb_pkg::LANES];
    logic [gsb_pkg::COORD_W-1:0] prod_reg [gsb_pkg::LANES];
    logic [gsb_pkg::COORD_W-1:0] res_reg  [gsb_pkg::LANES];
    logic                        status_reg;

    logic                            out_valid_reg;
    logic [gsb_pkg::OUT_DATA_W-1:0]  out_data_reg;
    logic                            out_status_reg;
    logic                            out_load;

    logic                        ram_we;
    logic [AW-1:0]               ram_addr;
    logic [gsb_pkg::PT_W-1:0]    ram_wdata;
    logic [gsb_pkg::PT_W-1:0]    ram_rdata;

    gsb_pkg::dim_t               sel_r;
    gsb_pkg::dim_t               sel_c;
    logic [AW-1:0]               corner_addr;

    logic [gsb_pkg::COORD_W-1:0]  rd        [gsb_pkg::LANES];
    logic signed [gsb_pkg::COORD_W:0] diff  [gsb_pkg::LANES];
    logic signed [49:0]           prod_full [gsb_pkg::LANES];
    logic [gsb_pkg::COORD_W-1:0]  prod_next [gsb_pkg::LANES];
    logic [gsb_pkg::COORD_W-1:0]  base      [gsb_pkg::LANES];
    logic [gsb_pkg::COORD_W-1:0]  lerp      [gsb_pkg::LANES];
    logic [gsb_pkg::FRAC_W-1:0]   tsel;

    gsb_ram #(
        .WIDTH (gsb_pkg::PT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // corner walk: 00, 01, 10, 11
    always_comb
    begin
        case (state_reg)
            gsb_pkg::B_S1:
            begin
                sel_r = desc_reg.r0;
                sel_c = desc_reg.c1;
            end
            gsb_pkg::B_S2:
            begin
                sel_r = desc_reg.r1;
                sel_c = desc_reg.c0;
            end
            gsb_pkg::B_S3:
            begin
                sel_r = desc_reg.r1;
                sel_c = desc_reg.c1;
            end
            default:
            begin
                sel_r = desc_reg.r0;
                sel_c = desc_reg.c0;
            end
        endcase
    end

    assign corner_addr = AW'(sel_r) * COLS_A + AW'(sel_c);
    assign clearing    = (state_reg == gsb_pkg::B_CLEAR);
    assign ram_we      = clearing || (state_reg == gsb_pkg::B_WRITE);
    assign ram_addr    = clearing ? clr_addr_reg : corner_addr;
    assign ram_wdata   = clearing ? '0 : desc_reg.pdata;
    assign out_load    = (state_reg == gsb_pkg::B_OUT) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gsb_pkg::B_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        case (state_reg)
            gsb_pkg::B_CLEAR:
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = gsb_pkg::B_IDLE;
                end
            end
            gsb_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    case (q_head.op)
                        gsb_pkg::OP_WRITE:  state_next = gsb_pkg::B_WRITE;
                        gsb_pkg::OP_READ:   state_next = gsb_pkg::B_RD0;
                        gsb_pkg::OP_SAMPLE: state_next = gsb_pkg::B_S0;
                        default:            state_next = gsb_pkg::B_OUT;
                    endcase
                end
            end
            gsb_pkg::B_WRITE: state_next = gsb_pkg::B_OUT;
            gsb_pkg::B_RD0:   state_next = gsb_pkg::B_RD1;
            gsb_pkg::B_RD1:   state_next = gsb_pkg::B_OUT;
            gsb_pkg::B_S0:    state_next = gsb_pkg::B_S1;
            gsb_pkg::B_S1:    state_next = gsb_pkg::B_S2;
            gsb_pkg::B_S2:    state_next = gsb_pkg::B_S3;
            gsb_pkg::B_S3:    state_next = gsb_pkg::B_S4;
            gsb_pkg::B_S4:    state_next = gsb_pkg::B_S5;
            gsb_pkg::B_S5:    state_next = gsb_pkg::B_S6;
            gsb_pkg::B_S6:    state_next = gsb_pkg::B_S7;
            gsb_pkg::B_S7:    state_next = gsb_pkg::B_OUT;
            gsb_pkg::B_OUT:
            begin
                if (out_load)
                begin
                    state_next = gsb_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = gsb_pkg::B_IDLE;
            end
        endcase
    end

    // one multiplier per lane, shared by the three lerps:
    // a + (((b - a) * t) >>> 16), low 32 bits are exact
    assign tsel = (state_reg == gsb_pkg::B_S6) ? desc_reg.tr : desc_reg.tc;

    always_comb
    begin
        for (int l = 0; l < gsb_pkg::LANES; l++)
        begin
            rd[l] = ram_rdata[l*gsb_pkg::COORD_W +: gsb_pkg::COORD_W];
            case (state_reg)
                gsb_pkg::B_S2:
                begin
                    diff[l] = $signed({rd[l][gsb_pkg::COORD_W-1], rd[l]})
                            - $signed({a_reg[l][gsb_pkg::COORD_W-1], a_reg[l]});
                end
                gsb_pkg::B_S4:
                begin
                    diff[l] = $signed({rd[l][gsb_pkg::COORD_W-1], rd[l]})
                            - $signed({c_reg[l][gsb_pkg::COORD_W-1], c_reg[l]});
                end
                default:
                begin
                    diff[l] = $signed({c_reg[l][gsb_pkg::COORD_W-1], c_reg[l]})
                            - $signed({top_reg[l][gsb_pkg::COORD_W-1], top_reg[l]});
                end
            endcase
            prod_full[l] = diff[l] * $signed({1'b0, tsel});
            prod_next[l] = prod_full[l][47:16];
            case (state_reg)
                gsb_pkg::B_S3: base[l] = a_reg[l];
                gsb_pkg::B_S5: base[l] = c_reg[l];
                default:       base[l] = top_reg[l];
            endcase
            lerp[l] = base[l] + prod_reg[l];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            desc_reg   <= q_head;
            status_reg <= (q_head.op == gsb_pkg::OP_FLAG);
        end
        for (int l = 0; l < gsb_pkg::LANES; l++)
        begin
            case (state_reg)
                gsb_pkg::B_IDLE: res_reg[l]  <= '0;
                gsb_pkg::B_RD1:  res_reg[l]  <= rd[l];
                gsb_pkg::B_S1:   a_reg[l]    <= rd[l];
                gsb_pkg::B_S2:   prod_reg[l] <= prod_next[l];
                gsb_pkg::B_S3:
                begin
                    c_reg[l]   <= rd[l];
                    top_reg[l] <= lerp[l];
                end
                gsb_pkg::B_S4:   prod_reg[l] <= prod_next[l];
                gsb_pkg::B_S5:   c_reg[l]    <= lerp[l];
                gsb_pkg::B_S6:   prod_reg[l] <= prod_next[l];
                gsb_pkg::B_S7:   res_reg[l]  <= lerp[l];
                default:
                begin
                end
            endcase
        end
        if (out_load)
        begin
            for (int l = 0; l < gsb_pkg::LANES; l++)
            begin
                out_data_reg[l*gsb_pkg::COORD_W +: gsb_pkg::COORD_W] <= res_reg[l];
            end
            out_status_reg <= status_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign out_status = out_status_reg;

endmodule
